[hw/rtl/ovq_pkg.sv]
// ----------------------------------------------------------------------------
// ovq_pkg
// Shared types, widths and codes for the ordered value queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ovq_pkg;

	// Default number of entries
	localparam int unsigned CAPACITY_DEF = 16;

	// Field widths
	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned STATUS_W = 2;

	// Stream payload widths, padded to whole bytes
	localparam int unsigned S_TDATA_W = 72;
	localparam int unsigned M_TDATA_W = 40;

	// Operation codes
	localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_SEARCH  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_MODIFY  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_DELETE  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_READOUT = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DUMP_RD,
		S_DUMP_OUT
	} state_t;

	// One result item
	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/ovq_ram.sv]
// ----------------------------------------------------------------------------
// ovq_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ovq_ram #(
	parameter int unsigned DEPTH = ovq_pkg::CAPACITY_DEF
) (
	input  wire                              clk,
	input  wire                              wr_en,
	input  wire [$clog2(DEPTH)-1:0]          wr_addr,
	input  wire [ovq_pkg::DATA_W-1:0]        wr_data,
	input  wire                              rd_en,
	input  wire [$clog2(DEPTH)-1:0]          rd_addr,
	output logic [ovq_pkg::DATA_W-1:0]       rd_data
);

	logic [ovq_pkg::DATA_W-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read one entry; hold the data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ovq_seq.sv]
// ----------------------------------------------------------------------------
// ovq_seq
// Sequencer: walks the entry store one entry at a time, through a single
// compare unit for search, modify and delete-with-shift, and in order for readout.
// ----------------------------------------------------------------------------
`default_nettype none

module ovq_seq #(
	parameter int unsigned CAPACITY = ovq_pkg::CAPACITY_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire [ovq_pkg::OPCODE_W-1:0]          in_opcode,
	input  wire [ovq_pkg::DATA_W-1:0]            in_key,
	input  wire [ovq_pkg::DATA_W-1:0]            in_repl,
	input  wire                                  out_free,
	output logic                                 res_valid,
	output ovq_pkg::res_t                        res
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	ovq_pkg::state_t                  state_q, state_d;
	logic [ovq_pkg::OPCODE_W-1:0]     op_q;
	logic [ovq_pkg::DATA_W-1:0]       key_q;
	logic [ovq_pkg::DATA_W-1:0]       repl_q;
	logic [ovq_pkg::STATUS_W-1:0]     status_q, status_d;
	logic                             pend_q, pend_d;
	logic [CW-1:0]                    idx_q, idx_d;
	logic [CW-1:0]                    cnt_q, cnt_d;
	logic [CW-1:0]                    idx_inc;
	logic [CW-1:0]                    idx_inc2;

	logic                             wr_en;
	logic [AW-1:0]                    wr_addr;
	logic [ovq_pkg::DATA_W-1:0]       wr_data;
	logic                             rd_en;
	logic [AW-1:0]                    rd_addr;
	logic [ovq_pkg::DATA_W-1:0]       rd_data;
	logic                             hit;

	ovq_ram #(
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign idx_inc  = idx_q + CW'(1);
	assign idx_inc2 = idx_q + CW'(2);

	// Shared compare unit
	assign hit = (rd_data == key_q);

	assign in_ready = (state_q == ovq_pkg::S_IDLE) && !pend_q;

	// State and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ovq_pkg::S_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= in_opcode;
			key_q  <= in_key;
			repl_q <= in_repl;
		end
		idx_q    <= idx_d;
		status_q <= status_d;
	end

	// Next state, store access and results
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		status_d  = status_q;
		pend_d    = pend_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q[AW-1:0];
		wr_data   = key_q;
		rd_en     = 1'b0;
		rd_addr   = idx_q[AW-1:0];
		res_valid = 1'b0;
		res       = '{status: status_q, value: '0, last: 1'b1};

		// Deliver a single-result status once the output side frees up
		if (pend_q && out_free) begin
			res_valid = 1'b1;
			pend_d    = 1'b0;
		end

		case (state_q)
			ovq_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					state_d = ovq_pkg::S_DISPATCH;
				end
			end
			ovq_pkg::S_DISPATCH: begin
				idx_d   = '0;
				state_d = ovq_pkg::S_IDLE;
				case (op_q)
					ovq_pkg::OP_INSERT: begin
						pend_d = 1'b1;
						if (cnt_q == CW'(CAPACITY)) begin
							status_d = ovq_pkg::ST_FULL;
						end else begin
							wr_en    = 1'b1;
							wr_addr  = cnt_q[AW-1:0];
							cnt_d    = cnt_q + CW'(1);
							status_d = ovq_pkg::ST_OK;
						end
					end
					ovq_pkg::OP_SEARCH, ovq_pkg::OP_MODIFY, ovq_pkg::OP_DELETE: begin
						if (cnt_q == '0) begin
							status_d = ovq_pkg::ST_EMPTY;
							pend_d   = 1'b1;
						end else begin
							state_d = ovq_pkg::S_SCAN_RD;
						end
					end
					ovq_pkg::OP_READOUT: begin
						if (cnt_q == '0) begin
							status_d = ovq_pkg::ST_EMPTY;
							pend_d   = 1'b1;
						end else begin
							state_d = ovq_pkg::S_DUMP_RD;
						end
					end
					default: begin
						status_d = ovq_pkg::ST_NOT_FOUND;
						pend_d   = 1'b1;
					end
				endcase
			end
			ovq_pkg::S_SCAN_RD: begin
				rd_en   = 1'b1;
				state_d = ovq_pkg::S_SCAN_CMP;
			end
			ovq_pkg::S_SCAN_CMP: begin
				if (hit) begin
					status_d = ovq_pkg::ST_OK;
					if (op_q == ovq_pkg::OP_DELETE && idx_inc < cnt_q) begin
						state_d = ovq_pkg::S_SHIFT_RD;
					end else begin
						pend_d  = 1'b1;
						state_d = ovq_pkg::S_IDLE;
						if (op_q == ovq_pkg::OP_MODIFY) begin
							wr_en   = 1'b1;
							wr_data = repl_q;
						end else if (op_q == ovq_pkg::OP_DELETE) begin
							cnt_d = cnt_q - CW'(1);
						end
					end
				end else if (idx_inc == cnt_q) begin
					status_d = ovq_pkg::ST_NOT_FOUND;
					pend_d   = 1'b1;
					state_d  = ovq_pkg::S_IDLE;
				end else begin
					idx_d   = idx_inc;
					state_d = ovq_pkg::S_SCAN_RD;
				end
			end
			ovq_pkg::S_SHIFT_RD: begin
				// Fetch the successor of the entry being overwritten
				rd_en   = 1'b1;
				rd_addr = idx_inc[AW-1:0];
				state_d = ovq_pkg::S_SHIFT_WR;
			end
			ovq_pkg::S_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_data = rd_data;
				if (idx_inc2 < cnt_q) begin
					idx_d   = idx_inc;
					state_d = ovq_pkg::S_SHIFT_RD;
				end else begin
					cnt_d   = cnt_q - CW'(1);
					pend_d  = 1'b1;
					state_d = ovq_pkg::S_IDLE;
				end
			end
			ovq_pkg::S_DUMP_RD: begin
				rd_en   = 1'b1;
				state_d = ovq_pkg::S_DUMP_OUT;
			end
			ovq_pkg::S_DUMP_OUT: begin
				// Emit one entry per free output slot
				if (out_free) begin
					res_valid = 1'b1;
					res       = '{status: ovq_pkg::ST_OK, value: rd_data,
						last: (idx_inc == cnt_q)};
					if (idx_inc == cnt_q) begin
						state_d = ovq_pkg::S_IDLE;
					end else begin
						idx_d   = idx_inc;
						state_d = ovq_pkg::S_DUMP_RD;
					end
				end
			end
			default: begin
				state_d = ovq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/ordered_value_queue.sv]
// Insert writes its entry at the tail and queues its status; search, modify and
// delete compare entries one at a time from the head, delete then shifts each
// later entry up one place; readout emits the entries in order, head first.
// One item at a time: the single compare unit and store read port set the rate.
// Reset clears the entry count and all control state; entry data is not cleared.
// ----------------------------------------------------------------------------
// ordered_value_queue
// Ordered store of signed 32-bit values, head to tail in insertion order,
// with insert, search, modify, delete and readout over item streams.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_value_queue #(
	parameter int unsigned CAPACITY = ovq_pkg::CAPACITY_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// [2:0] opcode, [34:3] key_value, [66:35] replacement_value, rest zero
	input  wire [ovq_pkg::S_TDATA_W-1:0]      s_tdata,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// [1:0] status, [33:2] item_value, rest zero
	output logic [ovq_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                              m_tlast
);

	localparam int unsigned PAD_W = ovq_pkg::M_TDATA_W - ovq_pkg::DATA_W - ovq_pkg::STATUS_W;

	logic          out_free;
	logic          res_valid;
	ovq_pkg::res_t res;
	ovq_pkg::res_t out_q;
	logic          m_tvalid_q;

	ovq_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tdata[2:0]),
		.in_key    (s_tdata[34:3]),
		.in_repl   (s_tdata[66:35]),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output slot is free when empty or being taken
	assign out_free = !m_tvalid_q || m_tready;

	// Hold one result item for the output stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_q.value, out_q.status};
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire

[hw/rtl/ovq_checker.sv]
// ----------------------------------------------------------------------------
// ovq_checker
// Port-level checks for the ordered value queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ovq_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_tvalid,
	input wire                              s_tready,
	input wire [ovq_pkg::S_TDATA_W-1:0]     s_tdata,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [ovq_pkg::M_TDATA_W-1:0]     m_tdata,
	input wire                              m_tlast
);

	// A stalled result item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	// A stalled result item keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result payload changed while stalled");

	// The block is busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after accept");

	// Any status other than ok closes the run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != ovq_pkg::ST_OK) |-> m_tlast)
		else $error("non-ok status without last");

	// Results with a status other than ok carry a zero value
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != ovq_pkg::ST_OK) |-> (m_tdata[33:2] == '0))
		else $error("non-ok status with nonzero value");

endmodule

bind ordered_value_queue ovq_checker u_ovq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

[tb/ovq_monitor.sv]
// ----------------------------------------------------------------------------
// ovq_monitor
// Watches both item streams of the ordered value queue. Each accepted
// command is applied to a local copy of the store, and the results it
// should cause are queued. Each accepted result is compared field by field
// with the oldest queued one.
// ----------------------------------------------------------------------------
`default_nettype none

module ovq_monitor #(
	parameter int unsigned CAPACITY = ovq_pkg::CAPACITY_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	input  wire                           s_tready,
	// [2:0] opcode, [34:3] key_value, [66:35] replacement_value, rest zero
	input  wire [ovq_pkg::S_TDATA_W-1:0]  s_tdata,
	input  wire                           m_tvalid,
	input  wire                           m_tready,
	// [1:0] status, [33:2] item_value, rest zero
	input  wire [ovq_pkg::M_TDATA_W-1:0]  m_tdata,
	input  wire                           m_tlast,
	output int                            fail_count,
	output int                            pending_count
);

	import ovq_pkg::*;

	// Local copy of the store, head at position zero
	logic [DATA_W-1:0] store_copy [CAPACITY];
	int unsigned       fill_level = 0;

	// Results still owed by the block, oldest first
	res_t owed_results [$];
	res_t want;
	res_t got;

	// Queue one owed result
	function automatic void owe_result(input logic [STATUS_W-1:0] status,
		input logic [DATA_W-1:0] value, input logic last);
		res_t r;
		r.status = status;
		r.value  = value;
		r.last   = last;
		owed_results.push_back(r);
	endfunction

	// Apply one command to the store copy and queue its results
	task automatic apply_command(input logic [OPCODE_W-1:0] op,
		input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] repl);
		int pos;
		int i;
		pos = -1;
		case (op)
			OP_INSERT: begin
				if (fill_level >= CAPACITY) begin
					owe_result(ST_FULL, '0, 1'b1);
				end else begin
					store_copy[fill_level] = key;
					fill_level++;
					owe_result(ST_OK, '0, 1'b1);
				end
			end
			OP_SEARCH, OP_MODIFY, OP_DELETE: begin
				if (fill_level == 0) begin
					owe_result(ST_EMPTY, '0, 1'b1);
				end else begin
					// Find the first match from the head
					for (i = 0; i < int'(fill_level); i++) begin
						if (pos < 0 && store_copy[i] == key)
							pos = i;
					end
					if (pos < 0) begin
						owe_result(ST_NOT_FOUND, '0, 1'b1);
					end else begin
						if (op == OP_MODIFY) begin
							store_copy[pos] = repl;
						end else if (op == OP_DELETE) begin
							// Close the gap, keeping order
							for (i = pos; i + 1 < int'(fill_level); i++)
								store_copy[i] = store_copy[i + 1];
							fill_level--;
						end
						owe_result(ST_OK, '0, 1'b1);
					end
				end
			end
			OP_READOUT: begin
				if (fill_level == 0) begin
					owe_result(ST_EMPTY, '0, 1'b1);
				end else begin
					for (i = 0; i < int'(fill_level); i++)
						owe_result(ST_OK, store_copy[i], (i + 1 == int'(fill_level)));
				end
			end
			default: begin
				owe_result(ST_NOT_FOUND, '0, 1'b1);
			end
		endcase
	endtask

	// Sample both channels at each edge
	always @(posedge clk) begin
		if (!arst_n) begin
			fill_level = 0;
			fail_count = 0;
			owed_results.delete();
		end else begin
			if (s_tvalid && s_tready)
				apply_command(s_tdata[2:0], s_tdata[34:3], s_tdata[66:35]);
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.value  = m_tdata[2 +: DATA_W];
				got.last   = m_tlast;
				if (owed_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: status %0d value %h last %0d",
							got.status, got.value, got.last);
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					if (got.status !== want.status || got.value !== want.value ||
						got.last !== want.last) begin
						if (fail_count < 10)
							$display({"result mismatch: expected status %0d value %h ",
								"last %0d, got status %0d value %h last %0d"},
								want.status, want.value, want.last,
								got.status, got.value, got.last);
						fail_count++;
					end
				end
			end
		end
		pending_count = owed_results.size();
	end

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives command items into the ordered value queue in random bursts while
// the result side stalls on its own pattern. A directed opening covers the
// empty, not-found, duplicate-key, head, tail and only-entry cases and the
// undefined opcodes; random fill and drain phases follow, reaching a full
// store. The monitor predicts and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import ovq_pkg::*;

	localparam int unsigned CAP         = CAPACITY_DEF;
	localparam int          RANDOM_ITEMS = 360;
	localparam int          PHASE_LEN    = 40;
	localparam int          POOL_SIZE    = 10;

	localparam logic [DATA_W-1:0] V_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] V_MAX  = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] V_NEG1 = 32'hffff_ffff;

	// Result-side stall modes
	localparam logic [1:0] RDY_ALWAYS  = 2'd0;
	localparam logic [1:0] RDY_RANDOM  = 2'd1;
	localparam logic [1:0] RDY_SPARSE  = 2'd2;
	localparam logic [1:0] RDY_PERIOD  = 2'd3;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	wire                   s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	wire                   m_tvalid;
	logic                  m_tready = 1'b0;
	wire  [M_TDATA_W-1:0]  m_tdata;
	wire                   m_tlast;
	int                    fail_count;
	int                    pending_count;

	logic [DATA_W-1:0]     key_pool [POOL_SIZE];
	int                    burst_left = 1;
	logic [7:0]            stall_tick = '0;
	logic [1:0]            stall_mode = RDY_ALWAYS;

	ordered_value_queue #(.CAPACITY(CAP)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	ovq_monitor #(.CAPACITY(CAP)) mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always #6 clk = ~clk;

	// Stall the result side, switching mode each time the 8-bit tick counter wraps
	always @(posedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		if (stall_tick == 8'd0)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
			RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:    m_tready <= stall_tick[2];
		endcase
	end

	// Hold one item until accepted, then close the burst with a gap if due
	task automatic issue(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] key,
		input logic [DATA_W-1:0] repl);
		int gap;
		s_tdata  <= {5'b0, repl, key, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 4);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				s_tdata  <= {$urandom, $urandom, $urandom};
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
	endtask

	// Draw a key, mostly from the pool so that matches happen
	function automatic logic [DATA_W-1:0] pick_key();
		if ($urandom_range(0, 9) < 8)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	// Draw an opcode, biased toward filling or draining the store
	function automatic logic [OPCODE_W-1:0] pick_op(input bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 3'($urandom_range(5, 7));
		if (filling) begin
			if (r < 63) return OP_INSERT;
			if (r < 71) return OP_SEARCH;
			if (r < 79) return OP_MODIFY;
			if (r < 89) return OP_DELETE;
		end else begin
			if (r < 18) return OP_INSERT;
			if (r < 33) return OP_SEARCH;
			if (r < 48) return OP_MODIFY;
			if (r < 85) return OP_DELETE;
		end
		return OP_READOUT;
	endfunction

	// Generous run limit
	initial begin
		#7_200_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [OPCODE_W-1:0] op;
		int                  issued;
		int                  k;
		issued = 0;
		key_pool[0] = V_MIN;
		key_pool[1] = V_MAX;
		key_pool[2] = '0;
		key_pool[3] = V_NEG1;
		key_pool[4] = 32'd1;
		for (k = 5; k < POOL_SIZE; k++)
			key_pool[k] = $urandom;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty store, then the only entry removed
		issue(OP_READOUT, $urandom, $urandom);
		issue(OP_SEARCH, V_MAX, $urandom);
		issue(OP_MODIFY, V_MIN, V_MAX);
		issue(OP_DELETE, '0, $urandom);
		issue(OP_INSERT, 32'd5, $urandom);
		issue(OP_DELETE, 32'd5, $urandom);
		issue(OP_READOUT, $urandom, $urandom);

		// Extremes, a duplicate key, head and tail deletes
		issue(OP_INSERT, V_MIN, $urandom);
		issue(OP_INSERT, V_MAX, $urandom);
		issue(OP_INSERT, '0, $urandom);
		issue(OP_INSERT, V_NEG1, $urandom);
		issue(OP_INSERT, V_MAX, $urandom);
		issue(OP_SEARCH, V_MAX, $urandom);
		issue(OP_SEARCH, 32'd1, $urandom);
		issue(OP_MODIFY, V_MAX, V_NEG1);
		issue(OP_DELETE, V_NEG1, $urandom);
		issue(OP_DELETE, V_MIN, $urandom);
		issue(OP_DELETE, V_MAX, $urandom);
		issue(OP_READOUT, $urandom, $urandom);

		// Undefined opcodes
		issue(3'd5, $urandom, $urandom);
		issue(3'd6, $urandom, $urandom);
		issue(3'd7, $urandom, $urandom);

		// Append after a tail delete
		issue(OP_INSERT, 32'd7, $urandom);
		issue(OP_READOUT, $urandom, $urandom);

		// Random fill and drain phases
		while (issued < RANDOM_ITEMS) begin
			op = pick_op(((issued / PHASE_LEN) % 2) == 0);
			issue(op, pick_key(), ($urandom_range(0, 1) != 0) ? pick_key() : $urandom);
			if (op <= OP_READOUT)
				issued++;
		end
		s_tvalid <= 1'b0;

		// Let the monitor take the last item before counting owed results
		@(posedge clk);

		// Drain the owed results, then let the block settle
		while (pending_count != 0)
			@(posedge clk);
		repeat (2 * CAP + 10) @(posedge clk);

		if (fail_count == 0 && pending_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
